[rtl/icsd_pkg.sv]
package icsd_pkg;

  // Audio bytes per output run
  localparam int unsigned CHUNK_BYTES = 32;
  localparam int unsigned FILL_W      = $clog2(CHUNK_BYTES + 1);

  localparam int unsigned AUDIO_W     = 20;
  localparam int unsigned META_W      = 12;
  localparam int unsigned HEX_W       = 32;
  localparam int unsigned CFG_W       = AUDIO_W;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [META_W-1:0] META_MAX_LEN = META_W'(1500);

  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_META_INTERVAL  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHUNKED_ENABLE = CFG_IDX_W'(1);

  // Result kinds
  localparam logic KIND_AUDIO = 1'b0;
  localparam logic KIND_META  = 1'b1;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] LOWER_A   = 8'h61;
  localparam logic [7:0] LOWER_Z   = 8'h7A;
  localparam logic [7:0] CASE_GAP  = 8'h20;
  localparam logic [7:0] ALPHA_GAP = 8'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       flush;
  } ent_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       run_end;
    logic       too_long;
  } res_t;

  // Fold to upper case, strip '0', close the gap between '9' and 'A'
  function automatic logic [7:0] hex_digit(input logic [7:0] b);
    logic [7:0] d;
    d = b;
    if (d >= LOWER_A && d <= LOWER_Z) d = d - CASE_GAP;
    d = d - CHAR_ZERO;
    if (d > 8'd9) d = d - ALPHA_GAP;
    return d;
  endfunction

endpackage

[rtl/icy_chunked_stream_demux.sv]
// Channel   Direction  tdata            tuser                       tlast
// s_axis    in         byte_in[7:0]     flush                       -
// m_axis    out        value[7:0]       kind (bit 0), too_long (1)  run_end
// cfg       in         index 0: meta_interval[19:0], index 1: chunked_enable
//
// One byte per cycle is taken on s_axis while the queue has room; the back end
// retires one queued byte per cycle while the output register is free or drained,
// set by the single state update. Bytes pass the queue, then the output register.
// Chunk-size bytes and metadata length bytes are consumed without a result.
// Reset clears all control state at once; no clearing pass is needed.
// A stall on m_axis fills the two-entry queue, then drops s_axis_tready.
module icy_chunked_stream_demux (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // byte_in
  input  logic                               s_axis_tuser,  // flush
  // Output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // value
  output logic [1:0]                         m_axis_tuser,  // kind, meta_too_long
  output logic                               m_axis_tlast,  // run_end
  // Configuration writes
  input  logic                               cfg_we_i,
  input  logic [icsd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [icsd_pkg::CFG_W-1:0]         cfg_wdata_i
);

  logic [icsd_pkg::AUDIO_W-1:0] meta_interval_q, meta_interval_d;
  logic                         chunked_en_q, chunked_en_d;
  logic                         reload;

  logic                         q_full;
  logic                         push;
  icsd_pkg::ent_t               push_ent;
  logic                         pop;
  logic                         q_valid;
  icsd_pkg::ent_t               q_head;
  icsd_pkg::res_t               res;

  // Register decode; writing the interval also restarts the audio count
  always_comb begin
    meta_interval_d = meta_interval_q;
    chunked_en_d    = chunked_en_q;
    reload          = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        icsd_pkg::REG_META_INTERVAL: begin
          meta_interval_d = cfg_wdata_i[icsd_pkg::AUDIO_W-1:0];
          reload          = 1'b1;
        end
        icsd_pkg::REG_CHUNKED_ENABLE: begin
          chunked_en_d = cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_interval_q <= '0;
      chunked_en_q    <= 1'b0;
    end else begin
      meta_interval_q <= meta_interval_d;
      chunked_en_q    <= chunked_en_d;
    end
  end

  // Front: strip HTTP chunk framing
  icsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chunked_en_i (chunked_en_q),
    .in_valid_i   (s_axis_tvalid),
    .in_data_i    (s_axis_tdata),
    .in_flush_i   (s_axis_tuser),
    .in_ready_o   (s_axis_tready),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_ent_o   (push_ent)
  );

  icsd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_ent_i (push_ent),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  // Back: split audio from metadata and mark run ends
  icsd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .meta_interval_i (meta_interval_q),
    .reload_i        (reload),
    .reload_val_i    (cfg_wdata_i[icsd_pkg::AUDIO_W-1:0]),
    .q_valid_i       (q_valid),
    .q_head_i        (q_head),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_res_o       (res)
  );

  assign m_axis_tdata = res.value;
  assign m_axis_tuser = {res.too_long, res.kind};
  assign m_axis_tlast = res.run_end;

endmodule

[rtl/icsd_front.sv]
module icsd_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             chunked_en_i,
  input  logic                             in_valid_i,
  input  logic [7:0]                       in_data_i,
  input  logic                             in_flush_i,
  output logic                             in_ready_o,
  input  logic                             q_full_i,
  output logic                             push_o,
  output icsd_pkg::ent_t                   push_ent_o
);

  logic                            accept;
  logic                            decode;
  logic [icsd_pkg::HEX_W-1:0]      hex_q, hex_d;
  logic [icsd_pkg::HEX_W-1:0]      xfer_left_q, xfer_left_d;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign decode     = chunked_en_i && !in_flush_i;

  // Size bytes stay here; everything else goes to the queue
  assign push_o           = accept && (!decode || (xfer_left_q != '0));
  assign push_ent_o.data  = in_data_i;
  assign push_ent_o.flush = in_flush_i;

  always_comb begin
    hex_d       = hex_q;
    xfer_left_d = xfer_left_q;
    if (accept && decode) begin
      if (xfer_left_q == '0) begin
        if (in_data_i == icsd_pkg::CHAR_LF) begin
          xfer_left_d = hex_q;
          hex_d       = '0;
        end else if (in_data_i != icsd_pkg::CHAR_CR) begin
          hex_d = {hex_q[icsd_pkg::HEX_W-5:0], 4'h0}
                  + icsd_pkg::HEX_W'(icsd_pkg::hex_digit(in_data_i));
        end
      end else begin
        xfer_left_d = xfer_left_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_q       <= '0;
      xfer_left_q <= '0;
    end else begin
      hex_q       <= hex_d;
      xfer_left_q <= xfer_left_d;
    end
  end

endmodule

[rtl/icsd_queue.sv]
module icsd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  icsd_pkg::ent_t push_ent_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output icsd_pkg::ent_t head_o
);

  icsd_pkg::ent_t                mem_q [icsd_pkg::QUEUE_DEPTH];
  logic [icsd_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [icsd_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [icsd_pkg::QCNT_W-1:0]   cnt_q, cnt_d;
  logic                          do_push;
  logic                          do_pop;

  assign full_o  = (cnt_q == icsd_pkg::QCNT_W'(icsd_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == icsd_pkg::QPTR_W'(icsd_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == icsd_pkg::QPTR_W'(icsd_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_ent_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[rtl/icsd_back.sv]
module icsd_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [icsd_pkg::AUDIO_W-1:0]      meta_interval_i,
  input  logic                              reload_i,
  input  logic [icsd_pkg::AUDIO_W-1:0]      reload_val_i,
  input  logic                              q_valid_i,
  input  icsd_pkg::ent_t                    q_head_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output icsd_pkg::res_t                    out_res_o
);

  logic                               in_meta_q, in_meta_d;
  logic                               first_q, first_d;
  logic                               disabled_q, disabled_d;
  logic [icsd_pkg::AUDIO_W-1:0]       audio_left_q, audio_left_d;
  logic [icsd_pkg::META_W-1:0]        meta_left_q, meta_left_d;
  logic [icsd_pkg::META_W-1:0]        meta_len_q, meta_len_d;
  logic [icsd_pkg::FILL_W-1:0]        fill_q, fill_d;
  logic                               out_valid_q, out_valid_d;
  icsd_pkg::res_t                     res_q, res_d;

  logic [icsd_pkg::FILL_W-1:0]        fill_inc;
  logic [icsd_pkg::AUDIO_W-1:0]       audio_dec;
  logic                               run_end;
  logic                               emit;
  logic                               too_long;

  // Advance only when the output register is free or being drained
  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  assign fill_inc  = fill_q + 1'b1;
  assign audio_dec = audio_left_q - 1'b1;

  always_comb begin
    in_meta_d    = in_meta_q;
    first_d      = first_q;
    disabled_d   = disabled_q;
    audio_left_d = audio_left_q;
    meta_left_d  = meta_left_q;
    meta_len_d   = meta_len_q;
    fill_d       = fill_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    res_d        = res_q;
    run_end      = 1'b0;
    emit         = 1'b0;
    too_long     = 1'b0;

    if (reload_i) audio_left_d = reload_val_i;

    if (pop_o) begin
      if (!in_meta_q) begin
        run_end = (fill_inc >= icsd_pkg::FILL_W'(icsd_pkg::CHUNK_BYTES)) || q_head_i.flush;
        fill_d  = run_end ? '0 : fill_inc;
        if ((meta_interval_i != '0) && !disabled_q) begin
          audio_left_d = audio_dec;
          if (audio_dec == '0) begin
            if (fill_d != '0) run_end = 1'b1;
            fill_d    = '0;
            in_meta_d = 1'b1;
            first_d   = 1'b1;
          end
        end
        out_valid_d    = 1'b1;
        res_d.kind     = icsd_pkg::KIND_AUDIO;
        res_d.value    = q_head_i.data;
        res_d.run_end  = run_end;
        res_d.too_long = 1'b0;
      end else begin
        if (first_q) begin
          // Length byte: block is sixteen bytes per count
          first_d     = 1'b0;
          meta_left_d = {q_head_i.data, 4'h0};
          meta_len_d  = '0;
        end else begin
          meta_left_d = meta_left_q - 1'b1;
          meta_len_d  = meta_len_q + 1'b1;
          emit        = 1'b1;
        end
        if (meta_left_d == '0) begin
          too_long     = (meta_len_d > icsd_pkg::META_MAX_LEN);
          disabled_d   = disabled_q || too_long;
          audio_left_d = disabled_d ? '0 : meta_interval_i;
          fill_d       = '0;
          in_meta_d    = 1'b0;
        end
        if (emit) begin
          out_valid_d    = 1'b1;
          res_d.kind     = icsd_pkg::KIND_META;
          res_d.value    = q_head_i.data;
          res_d.run_end  = (meta_left_d == '0);
          res_d.too_long = too_long;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_meta_q    <= 1'b0;
      first_q      <= 1'b0;
      disabled_q   <= 1'b0;
      audio_left_q <= '0;
      meta_left_q  <= '0;
      meta_len_q   <= '0;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      in_meta_q    <= in_meta_d;
      first_q      <= first_d;
      disabled_q   <= disabled_d;
      audio_left_q <= audio_left_d;
      meta_left_q  <= meta_left_d;
      meta_len_q   <= meta_len_d;
      fill_q       <= fill_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

[rtl/icsd_checker.sv]
module icsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  logic off_q;

  // Remember that a block overran and metadata is switched off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser[1]) begin
      off_q <= 1'b1;
    end
  end

  a_no_valid_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  a_too_long_on_meta_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] == icsd_pkg::KIND_META && m_axis_tlast)
    else $error("overrun flag outside the last metadata byte");

  a_no_meta_after_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && off_q |-> m_axis_tuser[0] == icsd_pkg::KIND_AUDIO)
    else $error("metadata byte after metadata was switched off");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled transaction changed");

endmodule

bind icy_chunked_stream_demux icsd_checker u_icsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[tb/sv/tb.sv]
module tb;

  // Cycles with no transaction on either stream before the run is abandoned
  localparam int unsigned STALL_LIMIT = 5000;
  // Cycles to let the block settle once the last expected byte has arrived
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata;  // byte_in[7:0]
  logic                           s_axis_tuser;  // flush
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [7:0]                     m_axis_tdata;  // value[7:0]
  logic [1:0]                     m_axis_tuser;  // bit 0 kind, bit 1 meta_too_long
  logic                           m_axis_tlast;  // run_end
  logic                           cfg_we_i;
  logic [icsd_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [icsd_pkg::CFG_W-1:0]     cfg_wdata_i;

  icy_chunked_stream_demux dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Idle rates in percent for the source and the sink
  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // Bytes the demultiplexer is expected to pass on, oldest first
  icsd_pkg::res_t expected_bytes[$];
  // Chunk-size header characters still to be sent
  logic [7:0] size_hdr[$];

  // Shadow of the configuration registers
  logic [icsd_pkg::AUDIO_W-1:0] cfg_interval;
  logic                         cfg_chunked;

  // Shadow of the demultiplexer and chunk decoder state
  logic                         exp_in_meta;
  logic                         exp_first_len;
  logic [icsd_pkg::AUDIO_W-1:0] exp_audio_left;
  logic [icsd_pkg::META_W-1:0]  exp_meta_left;
  logic [icsd_pkg::META_W-1:0]  exp_meta_count;
  logic                         exp_meta_off;
  logic [6:0]                   exp_run_fill;
  logic [icsd_pkg::HEX_W-1:0]   exp_size_acc;
  logic [icsd_pkg::HEX_W-1:0]   exp_xfer_left;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Route one byte that got past the chunk decoder: audio or metadata
  function automatic void route_byte(input logic [7:0] b, input logic fl);
    icsd_pkg::res_t r;
    logic run_end;
    logic emit;
    logic too_long;
    if (!exp_in_meta) begin
      run_end = 1'b0;
      exp_run_fill = exp_run_fill + 7'd1;
      if (exp_run_fill >= icsd_pkg::CHUNK_BYTES || fl) begin
        run_end = 1'b1;
        exp_run_fill = '0;
      end
      if (cfg_interval != '0 && !exp_meta_off) begin
        exp_audio_left = exp_audio_left - 1'b1;
        // Interval boundary: close the audio run and expect a length byte
        if (exp_audio_left == '0) begin
          if (exp_run_fill != '0) run_end = 1'b1;
          exp_run_fill  = '0;
          exp_in_meta   = 1'b1;
          exp_first_len = 1'b1;
        end
      end
      r.kind     = icsd_pkg::KIND_AUDIO;
      r.value    = b;
      r.run_end  = run_end;
      r.too_long = 1'b0;
      expected_bytes.push_back(r);
    end else begin
      emit = 1'b0;
      if (exp_first_len) begin
        // Length byte counts in units of 16; the extra one covers itself
        exp_first_len  = 1'b0;
        exp_meta_left  = {b, 4'h1};
        exp_meta_count = '0;
      end else begin
        exp_meta_count = exp_meta_count + 1'b1;
        emit = 1'b1;
      end
      exp_meta_left = exp_meta_left - 1'b1;
      if (exp_meta_left == '0) begin
        too_long = 1'b0;
        if (exp_meta_count > icsd_pkg::META_MAX_LEN) begin
          exp_meta_off = 1'b1;
          too_long     = 1'b1;
        end
        exp_audio_left = exp_meta_off ? '0 : cfg_interval;
        exp_run_fill   = '0;
        exp_in_meta    = 1'b0;
        if (emit) begin
          r.kind     = icsd_pkg::KIND_META;
          r.value    = b;
          r.run_end  = 1'b1;
          r.too_long = too_long;
          expected_bytes.push_back(r);
        end
      end else if (emit) begin
        r.kind     = icsd_pkg::KIND_META;
        r.value    = b;
        r.run_end  = 1'b0;
        r.too_long = 1'b0;
        expected_bytes.push_back(r);
      end
    end
  endfunction

  // Chunk decoder in front of the demultiplexer; flush bypasses it
  function automatic void predict_stream_byte(input logic [7:0] b, input logic fl);
    logic [7:0] digit;
    if (cfg_chunked && !fl) begin
      if (exp_xfer_left == '0) begin
        if (b == icsd_pkg::CHAR_CR) return;
        if (b == icsd_pkg::CHAR_LF) begin
          exp_xfer_left = exp_size_acc;
          exp_size_acc  = '0;
          return;
        end
        // Any other byte folds into the size, hex or not
        digit = b;
        if (digit >= icsd_pkg::LOWER_A && digit <= icsd_pkg::LOWER_Z) begin
          digit = digit - icsd_pkg::CASE_GAP;
        end
        digit = digit - icsd_pkg::CHAR_ZERO;
        if (digit > 8'd9) digit = digit - icsd_pkg::ALPHA_GAP;
        exp_size_acc = (exp_size_acc << 4) + {24'd0, digit};
        return;
      end
      exp_xfer_left = exp_xfer_left - 1'b1;
    end
    route_byte(b, fl);
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Sink: random back-pressure and result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    icsd_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte: kind=%0d value=%02h end=%0d too_long=%0d",
                                m_axis_tuser[0], m_axis_tdata, m_axis_tlast, m_axis_tuser[1]));
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tuser[0] !== want.kind || m_axis_tdata !== want.value ||
            m_axis_tlast !== want.run_end || m_axis_tuser[1] !== want.too_long) begin
          flag_mismatch({
            $sformatf("mismatch: expected kind=%0d value=%02h end=%0d too_long=%0d, ",
                      want.kind, want.value, want.run_end, want.too_long),
            $sformatf("got kind=%0d value=%02h end=%0d too_long=%0d",
                      m_axis_tuser[0], m_axis_tdata, m_axis_tlast, m_axis_tuser[1])});
        end
      end
    end
  end

  // Abandon the run once both streams have been silent for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL icy_chunked_stream_demux");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------

  // Offer one byte, hold it until the transaction completes, then predict it
  task automatic push_stream_byte(input logic [7:0] b, input logic fl);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= fl;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_stream_byte(b, fl);
  endtask

  // Drop valid, wait for every expected byte, then let the block settle
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; only call with the pipeline drained
  task automatic write_reg(input logic [icsd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [icsd_pkg::CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == icsd_pkg::REG_META_INTERVAL) begin
      cfg_interval   = val[icsd_pkg::AUDIO_W-1:0];
      exp_audio_left = val[icsd_pkg::AUDIO_W-1:0];
    end else begin
      cfg_chunked = val[0];
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] to_hex_char(input int unsigned v);
    if (v < 10) return icsd_pkg::CHAR_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : icsd_pkg::LOWER_A) + 8'(v - 10);
  endfunction

  // Queue a well-formed size line: one or two digits, optional CR, LF.
  // Now and then a stray non-hex character leads a one-digit size.
  task automatic queue_size_header();
    int unsigned n;
    n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 40);
    if (n < 16 && $urandom_range(0, 15) == 0) begin
      size_hdr.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h3A, 8'h40))
                                               : 8'($urandom_range(8'h67, 8'h7A)));
    end
    if (n >= 16) size_hdr.push_back(to_hex_char(n >> 4));
    size_hdr.push_back(to_hex_char(n & 15));
    if ($urandom_range(0, 4) != 0) size_hdr.push_back(icsd_pkg::CHAR_CR);
    size_hdr.push_back(icsd_pkg::CHAR_LF);
  endtask

  // Pick the next byte from the predicted state so that sequences stay
  // mostly well formed: size lines where a chunk is due, short lengths
  // where a metadata block opens, random bytes elsewhere, a few flushes
  task automatic send_random_item();
    logic [7:0] b;
    logic       fl;
    if (exp_in_meta && exp_first_len) begin
      b = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(3, 6));
    end else begin
      b = 8'($urandom_range(0, 255));
    end
    fl = ($urandom_range(0, 15) == 0);
    if (cfg_chunked && exp_xfer_left == '0 && !fl) begin
      if (size_hdr.size() == 0) queue_size_header();
      b = size_hdr.pop_front();
    end
    push_stream_byte(b, fl);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: plain audio, runs closed by flush
  task automatic test_audio_runs();
    push_stream_byte(8'h00, 1'b0);
    push_stream_byte(8'hFF, 1'b1);
    push_stream_byte(8'h5A, 1'b0);
    drain_pipeline();
  endtask

  // Interval of one: zero-length block, then a sixteen-byte block
  task automatic test_meta_blocks();
    write_reg(icsd_pkg::REG_CHUNKED_ENABLE, icsd_pkg::CFG_W'(0));
    write_reg(icsd_pkg::REG_META_INTERVAL, icsd_pkg::CFG_W'(1));
    push_stream_byte(8'h11, 1'b0);
    push_stream_byte(8'h00, 1'b0);
    push_stream_byte(8'h22, 1'b0);
    push_stream_byte(8'h01, 1'b1);
    for (int i = 0; i < 16; i++) begin
      push_stream_byte((i == 0) ? 8'hFF : 8'(i * 17), (i == 3));
    end
    drain_pipeline();
  endtask

  // Chunk framing: size one, zero size, non-hex size digit, flush bypass
  task automatic test_chunk_framing();
    write_reg(icsd_pkg::REG_META_INTERVAL, icsd_pkg::CFG_W'(0));
    write_reg(icsd_pkg::REG_CHUNKED_ENABLE, icsd_pkg::CFG_W'(1));
    push_stream_byte(8'h31, 1'b0);
    push_stream_byte(icsd_pkg::CHAR_CR, 1'b0);
    push_stream_byte(icsd_pkg::CHAR_LF, 1'b0);
    push_stream_byte(8'hC3, 1'b0);
    push_stream_byte(8'h30, 1'b0);
    push_stream_byte(icsd_pkg::CHAR_CR, 1'b0);
    push_stream_byte(icsd_pkg::CHAR_LF, 1'b0);
    push_stream_byte(icsd_pkg::CHAR_LF, 1'b1);
    push_stream_byte(8'h3A, 1'b0);
    push_stream_byte(icsd_pkg::CHAR_LF, 1'b0);
    push_stream_byte(8'h00, 1'b0);
    push_stream_byte(8'h7E, 1'b1);
    push_stream_byte(8'hFF, 1'b0);
    push_stream_byte(8'h80, 1'b0);
    drain_pipeline();
  endtask

  // Three idle patterns, each over several register settings
  task automatic test_random_traffic();
    int unsigned sel;
    logic [icsd_pkg::AUDIO_W-1:0] interval;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          src_idle_pct   = 8;
          sink_stall_pct = 76;
        end
        1: begin
          src_idle_pct   = 76;
          sink_stall_pct = 8;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        drain_pipeline();
        sel = $urandom_range(0, 5);
        case (sel)
          0:       interval = '0;
          1:       interval = icsd_pkg::AUDIO_W'(1);
          2:       interval = '1;
          default: interval = icsd_pkg::AUDIO_W'($urandom_range(2, 60));
        endcase
        write_reg(icsd_pkg::REG_META_INTERVAL, icsd_pkg::CFG_W'(interval));
        write_reg(icsd_pkg::REG_CHUNKED_ENABLE, icsd_pkg::CFG_W'($urandom_range(0, 1)));
        for (int k = 0; k < 80; k++) send_random_item();
      end
    end
    drain_pipeline();
  endtask

  // Shortest over-long block; metadata stays off afterwards
  task automatic test_meta_overflow();
    write_reg(icsd_pkg::REG_CHUNKED_ENABLE, icsd_pkg::CFG_W'(0));
    // Close any block left open by the random traffic
    while (exp_in_meta) begin
      push_stream_byte(exp_first_len ? 8'h00 : 8'($urandom_range(0, 255)), 1'b0);
    end
    drain_pipeline();
    write_reg(icsd_pkg::REG_META_INTERVAL, icsd_pkg::CFG_W'(3));
    for (int i = 0; i < 3; i++) push_stream_byte(8'($urandom_range(0, 255)), 1'b0);
    push_stream_byte(8'd94, 1'b0);
    for (int i = 0; i < 1504; i++) begin
      push_stream_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    drain_pipeline();
    write_reg(icsd_pkg::REG_META_INTERVAL, icsd_pkg::CFG_W'(2));
    for (int i = 0; i < 40; i++) send_random_item();
    drain_pipeline();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= icsd_pkg::REG_META_INTERVAL;
    cfg_wdata_i   <= '0;

    cfg_interval   = '0;
    cfg_chunked    = 1'b0;
    exp_in_meta    = 1'b0;
    exp_first_len  = 1'b0;
    exp_audio_left = '0;
    exp_meta_left  = '0;
    exp_meta_count = '0;
    exp_meta_off   = 1'b0;
    exp_run_fill   = '0;
    exp_size_acc   = '0;
    exp_xfer_left  = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_audio_runs();
    test_meta_blocks();
    test_chunk_framing();
    test_random_traffic();
    test_meta_overflow();

    if (mismatch_count == 0) begin
      $display("PASS icy_chunked_stream_demux");
    end else begin
      $display("FAIL icy_chunked_stream_demux");
    end
    $finish;
  end

endmodule
